### rtl/crcfc_pkg.sv
package crcfc_pkg;

    localparam logic [1:0] MODE_CRC8  = 2'd0;
    localparam logic [1:0] MODE_CRC16 = 2'd1;
    localparam logic [1:0] MODE_CRC24 = 2'd2;

    localparam logic [7:0]  CRC8_POLY  = 8'h07;
    localparam logic [15:0] CRC16_POLY = 16'h1021;
    localparam logic [15:0] CRC16_INIT = 16'hFFFF;
    localparam logic [23:0] CRC24_POLY = 24'h800063;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_crc_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic        crc_error;
        logic [23:0] crc_value;
    } t_out_item;

    typedef struct packed {
        logic [23:0] crc_register;
        logic [1:0]  trailer_count;
        logic        mismatch_seen;
    } t_crc_state;

    function automatic logic [23:0] mode_init(logic [1:0] mode);
        logic [23:0] v;
        case (mode)
            MODE_CRC16: v = {8'h00, CRC16_INIT};
            default:    v = 24'h000000;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] mode_nbytes(logic [1:0] mode);
        logic [1:0] n;
        case (mode)
            MODE_CRC16: n = 2'd2;
            MODE_CRC24: n = 2'd3;
            default:    n = 2'd1;
        endcase
        return n;
    endfunction

    function automatic t_crc_state restart_state(logic [1:0] mode);
        t_crc_state s;
        s.crc_register  = mode_init(mode);
        s.trailer_count = 2'd0;
        s.mismatch_seen = 1'b0;
        return s;
    endfunction

    // One byte through an MSB-first CRC, eight bit steps unrolled.
    function automatic logic [23:0] crc_step(logic [1:0] mode, logic [23:0] r,
                                             logic [7:0] b);
        logic [7:0]  c8;
        logic [15:0] c16;
        logic [23:0] c24;
        logic [23:0] res;
        c8  = r[7:0] ^ b;
        c16 = r[15:0] ^ {b, 8'h00};
        c24 = r ^ {b, 16'h0000};
        for (int i = 0; i < 8; i++) begin
            c8  = c8[7]   ? ({c8[6:0], 1'b0} ^ CRC8_POLY)    : {c8[6:0], 1'b0};
            c16 = c16[15] ? ({c16[14:0], 1'b0} ^ CRC16_POLY) : {c16[14:0], 1'b0};
            c24 = c24[23] ? ({c24[22:0], 1'b0} ^ CRC24_POLY) : {c24[22:0], 1'b0};
        end
        case (mode)
            MODE_CRC16: res = {8'h00, c16};
            MODE_CRC24: res = c24;
            default:    res = {16'h0000, c8};
        endcase
        return res;
    endfunction

endpackage

### rtl/crcfc_update.sv
module crcfc_update
    import crcfc_pkg::*;
(
    input  logic [1:0] i_mode,
    input  t_crc_state i_state,
    input  t_in_item   i_item,
    output t_crc_state o_next_state,
    output t_out_item  o_result
);

    logic [1:0]  nbytes;
    logic [7:0]  expect_byte;
    t_crc_state  upd;

    assign nbytes = mode_nbytes(i_mode);

    always_comb begin
        case (i_state.trailer_count)
            2'd1:    expect_byte = i_state.crc_register[15:8];
            2'd2:    expect_byte = i_state.crc_register[23:16];
            default: expect_byte = i_state.crc_register[7:0];
        endcase
    end

    always_comb begin
        upd = i_state;
        if (i_item.is_crc_byte) begin
            if (i_state.trailer_count < nbytes && expect_byte != i_item.data_byte) begin
                upd.mismatch_seen = 1'b1;
            end
            if (i_state.trailer_count != 2'd3) begin
                upd.trailer_count = i_state.trailer_count + 2'd1;
            end
        end else begin
            upd.crc_register = crc_step(i_mode, i_state.crc_register, i_item.data_byte);
        end
    end

    assign o_result.crc_error = upd.mismatch_seen || (upd.trailer_count < nbytes);
    assign o_result.crc_value = upd.crc_register;
    assign o_next_state = i_item.frame_end ? restart_state(i_mode) : upd;

endmodule

### rtl/crc_frame_checker_multi_width.sv
// CRC frame checker, CRC-8 / CRC-16 / CRC-24 selected by a mode register.
// Input channel: i_in_valid / o_in_stall carry one received byte per item,
// flagged as payload or trailer and optionally as the frame's last byte.
// Output channel: o_out_valid / i_out_stall carry one verdict item per frame
// end: crc_error and the CRC computed over the payload.
// Config channel: i_cfg_valid / o_cfg_ready writes crc_mode; a write also
// restarts the frame. o_cfg_ready is high while no byte waits in the input
// register.
// Path: a byte is registered on accept and then processed from the input
// register; a frame-end verdict is then registered in the output register.
// Throughput: one byte per cycle unless a frame end waits on a stalled
// verdict; one-byte CRC step unrolled from input reg to state/result regs.
// Reset: mode CRC-8, CRC register zero, trailer state cleared, no items held.
// Stall: while a verdict waits on the output, payload and trailer bytes keep
// flowing; only a frame-end byte waits in the input register, and then the
// input channel stalls.
module crc_frame_checker_multi_width
    import crcfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    logic       r_in_valid, n_in_valid;
    t_in_item   r_in;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out;
    logic [1:0] r_mode;
    t_crc_state r_state;
    t_crc_state next_state;
    t_out_item  result;
    logic       out_free;
    logic       adv;
    logic       in_acc;
    logic       cfg_wr;

    crcfc_update u_update (
        .i_mode       (r_mode),
        .i_state      (r_state),
        .i_item       (r_in),
        .o_next_state (next_state),
        .o_result     (result)
    );

    assign out_free    = !r_out_valid || !i_out_stall;
    assign adv         = r_in_valid && (!r_in.frame_end || out_free);
    assign o_in_stall  = r_in_valid && !adv;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = !r_in_valid;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_acc) begin
            n_in_valid = 1'b1;
        end else if (adv) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (adv && r_in.frame_end) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_CRC8;
            r_state     <= restart_state(MODE_CRC8);
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                r_mode  <= i_cfg_data;
                r_state <= restart_state(i_cfg_data);
            end else if (adv) begin
                r_state <= next_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_item;
        end
        if (adv && r_in.frame_end) begin
            r_out <= result;
        end
    end

    a_restart_after_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.frame_end) |=>
            (r_state.trailer_count == 2'd0 && !r_state.mismatch_seen))
        else $error("trailer state not cleared after frame end");

    a_crc8_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_CRC16 && r_mode != MODE_CRC24) |->
            (r_state.crc_register[23:8] == 16'h0000))
        else $error("CRC-8 register has bits above its width");

    a_crc16_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_CRC16) |-> (r_state.crc_register[23:16] == 8'h00))
        else $error("CRC-16 register has bits above its width");

    a_verdict_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in.frame_end && r_out_valid && i_out_stall) |->
            (o_in_stall && !adv))
        else $error("frame end advanced over a stalled verdict");

endmodule
